@@ sv/svcls_pkg.sv @@
// Package for the VP9 SVC layer selector: descriptor flag masks, register map,
// and the structs passed between the decoder, the layer controller and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package svcls_pkg;

    // Layer id width and the all-layers value loaded into the target registers at reset.
    localparam int unsigned LayerWidth  = 3;
    localparam int unsigned HeadWidth   = 32;
    localparam int unsigned SeqWidth    = 32;
    localparam int unsigned ApbAddrWidth = 3;
    localparam int unsigned ApbDataWidth = 32;

    localparam logic [LayerWidth-1:0] LayerAll = 3'd7;

    // Register indexes, selected by address bit 2.
    localparam logic RegTargetTemporal = 1'b0;
    localparam logic RegTargetSpatial  = 1'b1;

    // Descriptor byte 0 flag masks.
    localparam logic [7:0] FlagI = 8'h80;
    localparam logic [7:0] FlagP = 8'h40;
    localparam logic [7:0] FlagL = 8'h20;
    localparam logic [7:0] FlagB = 8'h08;
    localparam logic [7:0] FlagE = 8'h04;

    // Picture id M bit (two-byte picture id) and layer byte switch bit.
    localparam logic [7:0] PicIdLong = 8'h80;
    localparam logic [7:0] LayerSw   = 8'h10;

    // Fields of the descriptor that the layer decisions need.
    typedef struct packed {
        logic                  f_p;
        logic                  f_b;
        logic                  f_e;
        logic                  sw;
        logic [LayerWidth-1:0] tid;
        logic [LayerWidth-1:0] sid;
    } desc_t;

    // Outcome for one item.
    typedef struct packed {
        logic forwarded;
        logic frame_end_hit;
    } decision_t;

endpackage

@@ sv/svcls_desc_decode.sv @@
// Descriptor decoder: extracts flags and layer ids from the first four payload bytes.
// Depends on svcls_pkg.
`timescale 1ns / 1ps

module svcls_desc_decode (
    input  logic [svcls_pkg::HeadWidth-1:0] head,
    output svcls_pkg::desc_t                desc
);
    import svcls_pkg::*;

    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] layer_byte;

    assign byte0 = head[31:24];
    assign byte1 = head[23:16];

    // The layer byte follows the optional one- or two-byte picture id.
    always_comb begin
        if ((byte0 & FlagI) == 8'h00) begin
            layer_byte = head[23:16];
        end else if ((byte1 & PicIdLong) != 8'h00) begin
            layer_byte = head[7:0];
        end else begin
            layer_byte = head[15:8];
        end
    end

    // Layer fields read as zero when the layer byte is absent.
    always_comb begin
        desc.f_p = (byte0 & FlagP) != 8'h00;
        desc.f_b = (byte0 & FlagB) != 8'h00;
        desc.f_e = (byte0 & FlagE) != 8'h00;
        if ((byte0 & FlagL) != 8'h00) begin
            desc.sw  = (layer_byte & LayerSw) != 8'h00;
            desc.tid = layer_byte[7:5];
            desc.sid = layer_byte[3:1];
        end else begin
            desc.sw  = 1'b0;
            desc.tid = '0;
            desc.sid = '0;
        end
    end

endmodule

@@ sv/svcls_layer_ctrl.sv @@
// Layer controller: current temporal and spatial layers, the drop counter,
// and the forward or drop decision for the item being processed.
// Depends on svcls_pkg.
`timescale 1ns / 1ps

module svcls_layer_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  svcls_pkg::desc_t                 desc,
    input  logic [svcls_pkg::LayerWidth-1:0] target_temporal,
    input  logic [svcls_pkg::LayerWidth-1:0] target_spatial,
    output svcls_pkg::decision_t             decision,
    output logic [svcls_pkg::SeqWidth-1:0]   drop_count
);
    import svcls_pkg::*;

    logic [LayerWidth-1:0] cur_temporal_reg, cur_temporal_next;
    logic [LayerWidth-1:0] cur_spatial_reg, cur_spatial_next;
    logic [SeqWidth-1:0]   drop_count_reg, drop_count_next;
    logic                  temporal_drop;
    logic                  spatial_drop;

    // Temporal layer: upswitch on a switch point at frame start, downswitch at frame end.
    always_comb begin
        cur_temporal_next = cur_temporal_reg;
        if (target_temporal > cur_temporal_reg) begin
            if (desc.sw && desc.f_b && (desc.tid <= target_temporal)) begin
                cur_temporal_next = desc.tid;
            end
        end else if (target_temporal < cur_temporal_reg) begin
            if (desc.f_e) begin
                cur_temporal_next = target_temporal;
            end
        end
    end

    assign temporal_drop = cur_temporal_reg < desc.tid;

    // Spatial layer: step up by one at a frame start with no P flag, down at frame end.
    // It is left alone when the item is already dropped on its temporal layer.
    always_comb begin
        cur_spatial_next = cur_spatial_reg;
        if (!temporal_drop) begin
            if (target_spatial > cur_spatial_reg) begin
                if (!desc.f_p && desc.f_b && (cur_spatial_reg != LayerAll)
                    && (desc.sid == cur_spatial_reg + 3'd1)) begin
                    cur_spatial_next = desc.sid;
                end
            end else if (target_spatial < cur_spatial_reg) begin
                if (desc.f_e) begin
                    cur_spatial_next = target_spatial;
                end
            end
        end
    end

    assign spatial_drop = cur_spatial_reg < desc.sid;

    // Decision and drop counting.
    always_comb begin
        decision.forwarded     = !temporal_drop && !spatial_drop;
        decision.frame_end_hit = desc.f_e && (cur_spatial_next == desc.sid);
        drop_count_next        = drop_count_reg;
        if (temporal_drop || spatial_drop) begin
            drop_count_next = drop_count_reg + 32'd1;
        end
    end

    assign drop_count = drop_count_reg;

    // State registers advance once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_temporal_reg <= '0;
            cur_spatial_reg  <= '0;
            drop_count_reg   <= '0;
        end else if (advance) begin
            cur_temporal_reg <= cur_temporal_next;
            cur_spatial_reg  <= cur_spatial_next;
            drop_count_reg   <= drop_count_next;
        end
    end

endmodule

@@ sv/vp9_svc_layer_selector_unit.sv @@
// Top level of the VP9 SVC layer selector: stream ports, APB target registers,
// input and result registers. Depends on svcls_pkg, svcls_desc_decode, svcls_layer_ctrl.
`timescale 1ns / 1ps

// Takes one packet per item (descriptor head, extended sequence number, marker) and
// returns one decision per item: m_tuser says forward (1) or drop (0), m_tdata carries the
// rewritten sequence number and m_tlast the marker to send; both are zero for a dropped
// packet. An item passes an input register and then a result register. A new item is
// taken every cycle while m_tready is high; the layer state and drop counter update at the
// edge that loads the result register. Target registers at APB addresses 0 (temporal) and
// 4 (spatial) reset to 7 and should be written only while no items are in flight.
module vp9_svc_layer_selector_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,  // [31:0] payload_head, [63:32] ext_seq
    input  logic                               s_tlast,  // rtp_marker
    // Result items.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,  // [31:0] out_seq
    output logic                               m_tuser,  // [0] forwarded
    output logic                               m_tlast,  // out_marker
    // Configuration.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [svcls_pkg::ApbAddrWidth-1:0] paddr,
    input  logic [svcls_pkg::ApbDataWidth-1:0] pwdata,
    output logic [svcls_pkg::ApbDataWidth-1:0] prdata,
    output logic                               pready
);
    import svcls_pkg::*;

    logic [LayerWidth-1:0] target_temporal_reg;
    logic [LayerWidth-1:0] target_spatial_reg;
    logic                  cfg_write;

    logic                  in_valid_reg;
    logic [HeadWidth-1:0]  in_head_reg;
    logic [SeqWidth-1:0]   in_seq_reg;
    logic                  in_marker_reg;

    logic                  out_valid_reg;
    logic [SeqWidth-1:0]   out_seq_reg, out_seq_next;
    logic                  out_fwd_reg;
    logic                  out_marker_reg, out_marker_next;

    logic                  advance;
    logic [SeqWidth-1:0]   drop_count;
    desc_t                 desc;
    decision_t             decision;

    // APB register file.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_temporal_reg <= LayerAll;
            target_spatial_reg  <= LayerAll;
        end else if (cfg_write) begin
            unique case (paddr[2])
                RegTargetTemporal: target_temporal_reg <= pwdata[LayerWidth-1:0];
                RegTargetSpatial:  target_spatial_reg  <= pwdata[LayerWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            RegTargetTemporal: prdata = {{(ApbDataWidth-LayerWidth){1'b0}}, target_temporal_reg};
            RegTargetSpatial:  prdata = {{(ApbDataWidth-LayerWidth){1'b0}}, target_spatial_reg};
            default:           prdata = '0;
        endcase
    end

    // Handshake: the item in the input register moves on when the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_head_reg   <= s_tdata[31:0];
            in_seq_reg    <= s_tdata[63:32];
            in_marker_reg <= s_tlast;
        end
    end

    svcls_desc_decode u_decode (
        .head (in_head_reg),
        .desc (desc)
    );

    svcls_layer_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .desc            (desc),
        .target_temporal (target_temporal_reg),
        .target_spatial  (target_spatial_reg),
        .decision        (decision),
        .drop_count      (drop_count)
    );

    // Result fields; a dropped item carries zeros.
    always_comb begin
        if (decision.forwarded) begin
            out_seq_next    = in_seq_reg - drop_count;
            out_marker_next = in_marker_reg || decision.frame_end_hit;
        end else begin
            out_seq_next    = '0;
            out_marker_next = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_seq_reg    <= out_seq_next;
            out_fwd_reg    <= decision.forwarded;
            out_marker_reg <= out_marker_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_seq_reg;
    assign m_tuser  = out_fwd_reg;
    assign m_tlast  = out_marker_reg;

endmodule

@@ sv/svcls_checker.sv @@
// Port-level checks for the VP9 SVC layer selector, bound to the top level.
// Depends on vp9_svc_layer_selector_unit.
`timescale 1ns / 1ps

module svcls_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast,
    input logic [31:0] prdata
);

    // A stalled result holds its content.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // A dropped item carries no sequence number and no marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0 && !m_tlast)
        else $error("dropped item has nonzero fields");

    // Both target registers read back as all-layers after reset.
    assert property (@(posedge aclk)
        !aresetn |=> prdata == 32'd7)
        else $error("target register reset value wrong");

    // An item accepted while m_tready is high shows a result once it has passed the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tready |=> ##1 m_tvalid)
        else $error("accepted item produced no result");

endmodule

bind vp9_svc_layer_selector_unit svcls_props u_svcls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .prdata   (prdata)
);

@@ tb/sv/svcls_checker.sv @@
// Checker for the VP9 SVC layer selector: watches the stream and APB ports, predicts
// the decision for each accepted packet and compares it with the result items.
// Depends on svcls_pkg.
`timescale 1ns / 1ps

module svcls_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [63:0]                         s_tdata,   // [31:0] payload_head, [63:32] ext_seq
    input  logic                                s_tlast,   // rtp_marker
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [31:0]                         m_tdata,   // [31:0] out_seq
    input  logic                                m_tuser,   // [0] forwarded
    input  logic                                m_tlast,   // out_marker
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [svcls_pkg::ApbAddrWidth-1:0]  paddr,
    input  logic [svcls_pkg::ApbDataWidth-1:0]  pwdata,
    input  logic [svcls_pkg::ApbDataWidth-1:0]  prdata,
    input  logic                                pready,
    output int unsigned                         errors,
    output int unsigned                         pending
);
    import svcls_pkg::*;

    localparam logic [ApbAddrWidth-1:0] AddrTemporal = {RegTargetTemporal, 2'b00};
    localparam logic [ApbAddrWidth-1:0] AddrSpatial  = {RegTargetSpatial, 2'b00};

    // One expected decision per accepted packet.
    typedef struct packed {
        logic        forwarded;
        logic [31:0] seq;
        logic        marker;
    } pkt_verdict_t;

    logic [LayerWidth-1:0] tgt_tl;
    logic [LayerWidth-1:0] tgt_sl;
    logic [LayerWidth-1:0] cur_tl;
    logic [LayerWidth-1:0] cur_sl;
    logic [31:0]           dropped;
    pkt_verdict_t          verdicts_due[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < 50) begin
            $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        end
        errors++;
    endtask

    // Decode the descriptor head, move the current layers toward the targets and
    // decide whether the packet goes out, with its rewritten sequence number.
    function automatic pkt_verdict_t select_layers(input logic [31:0] head,
                                                   input logic [31:0] seq,
                                                   input logic marker);
        logic [7:0]            b0;
        logic [7:0]            lb;
        logic                  f_p;
        logic                  f_l;
        logic                  f_b;
        logic                  f_e;
        logic                  sw;
        logic [LayerWidth-1:0] tid;
        logic [LayerWidth-1:0] sid;
        logic [LayerWidth-1:0] was_tl;
        logic [LayerWidth-1:0] was_sl;
        pkt_verdict_t          v;

        b0  = head[31:24];
        f_p = (b0 & FlagP) != 8'h00;
        f_l = (b0 & FlagL) != 8'h00;
        f_b = (b0 & FlagB) != 8'h00;
        f_e = (b0 & FlagE) != 8'h00;

        // The layer byte follows the picture id, which is one or two bytes long.
        if ((b0 & FlagI) == 8'h00) begin
            lb = head[23:16];
        end else if ((head[23:16] & PicIdLong) != 8'h00) begin
            lb = head[7:0];
        end else begin
            lb = head[15:8];
        end
        tid = f_l ? lb[7:5] : '0;
        sw  = f_l && ((lb & LayerSw) != 8'h00);
        sid = f_l ? lb[3:1] : '0;

        v = '0;

        // Temporal layer: switch up at a switching point, down at a frame end.
        was_tl = cur_tl;
        if (tgt_tl > cur_tl) begin
            if (sw && f_b && tid <= tgt_tl) cur_tl = tid;
        end else if (tgt_tl < cur_tl && f_e) begin
            cur_tl = tgt_tl;
        end
        if (tid > was_tl) begin
            dropped = dropped + 32'd1;
            return v;
        end

        // Spatial layer: step up one layer at a time, only without inter-picture prediction.
        was_sl = cur_sl;
        if (tgt_sl > cur_sl) begin
            if (!f_p && f_b && {1'b0, sid} == {1'b0, cur_sl} + 4'd1) cur_sl = sid;
        end else if (tgt_sl < cur_sl && f_e) begin
            cur_sl = tgt_sl;
        end
        if (sid > was_sl) begin
            dropped = dropped + 32'd1;
            return v;
        end

        v.forwarded = 1'b1;
        v.seq       = seq - dropped;
        v.marker    = marker || (f_e && cur_sl == sid);
        return v;
    endfunction

    always @(posedge aclk) begin : monitor
        pkt_verdict_t want;
        if (!aresetn) begin
            tgt_tl  = LayerAll;
            tgt_sl  = LayerAll;
            cur_tl  = '0;
            cur_sl  = '0;
            dropped = '0;
            verdicts_due.delete();
        end else begin
            // Register accesses, only made while no packets are in flight.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == AddrTemporal) tgt_tl = pwdata[LayerWidth-1:0];
                    else if (paddr == AddrSpatial) tgt_sl = pwdata[LayerWidth-1:0];
                end else if (paddr == AddrTemporal) begin
                    if (prdata !== {29'b0, tgt_tl}) report_mismatch("target_temporal read", prdata,
                                                                    {29'b0, tgt_tl});
                end else if (paddr == AddrSpatial) begin
                    if (prdata !== {29'b0, tgt_sl}) report_mismatch("target_spatial read", prdata,
                                                                    {29'b0, tgt_sl});
                end
            end

            // Result items against the oldest expectation.
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch("unexpected result item", m_tdata, 32'h0);
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_tuser !== want.forwarded)
                        report_mismatch("forwarded", {31'b0, m_tuser}, {31'b0, want.forwarded});
                    if (m_tdata !== want.seq)
                        report_mismatch("out_seq", m_tdata, want.seq);
                    if (m_tlast !== want.marker)
                        report_mismatch("out_marker", {31'b0, m_tlast}, {31'b0, want.marker});
                end
            end

            // Accepted packets go to the back of the queue.
            if (s_tvalid && s_tready) begin
                verdicts_due.insert(verdicts_due.size(),
                                    select_layers(s_tdata[31:0], s_tdata[63:32], s_tlast));
            end
        end
        pending <= verdicts_due.size();
    end

endmodule

@@ tb/sv/tb_vp9_svc_layer_selector_unit.sv @@
// Testbench top for the VP9 SVC layer selector: drives packets and target registers,
// stalls the result side, and gives the verdict from the checker's error count.
// Depends on svcls_pkg, svcls_checker and vp9_svc_layer_selector_unit.
`timescale 1ns / 1ps

module tb_vp9_svc_layer_selector_unit;
    import svcls_pkg::*;

    localparam int unsigned CycleLimit   = 200000;
    localparam int unsigned HoldCycles   = 300;
    localparam int unsigned PhaseCount   = 10;
    localparam int unsigned PhasePackets = 165;

    localparam logic [ApbAddrWidth-1:0] AddrTemporal = {RegTargetTemporal, 2'b00};
    localparam logic [ApbAddrWidth-1:0] AddrSpatial  = {RegTargetSpatial, 2'b00};

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [63:0]             s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [31:0]             m_tdata;
    logic                    m_tuser;
    logic                    m_tlast;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ApbAddrWidth-1:0] paddr;
    logic [ApbDataWidth-1:0] pwdata;
    logic [ApbDataWidth-1:0] prdata;
    logic                    pready;

    int unsigned errors;
    int unsigned pending;
    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    int unsigned packets_sent = 0;
    logic [31:0] next_seq;
    logic        hold_req = 1'b0;

    vp9_svc_layer_selector_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    svcls_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready),
        .errors(errors), .pending(pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_vp9_svc_layer_selector_unit: errors");
            $finish;
        end
    end

    // Result side: random stall patterns, each held for a random span, plus one long
    // hold-off so the block fills up and pushes back on the input.
    initial begin : result_sink
        int unsigned mode;
        int unsigned span;
        int unsigned phase;
        logic        hold_done;
        mode      = 0;
        span      = 0;
        phase     = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (HoldCycles) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (span == 0) begin
                mode  = $urandom_range(0, 3);
                span  = $urandom_range(16, 96);
                phase = 0;
            end
            span--;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                2: m_tready = ($urandom_range(0, 7) != 0);
                default: m_tready = (phase % 3 == 0);
            endcase
            phase++;
        end
    end

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [ApbAddrWidth-1:0] addr,
                              input logic [LayerWidth-1:0] val);
        logic [31:0] fill;
        fill    = $urandom();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = {fill[31:LayerWidth], val};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Stop sending and wait until every decision has come back.
    task automatic settle();
        s_tvalid   = 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (pending != 0);
    endtask

    task automatic set_targets(input logic [LayerWidth-1:0] tl, input logic [LayerWidth-1:0] sl);
        settle();
        apb_access(1'b1, AddrTemporal, tl);
        apb_access(1'b1, AddrSpatial, sl);
        apb_access(1'b0, AddrTemporal, '0);
        apb_access(1'b0, AddrSpatial, '0);
    endtask

    // Offer one packet; the sender runs in bursts with random gaps between them.
    task automatic send_packet(input logic [31:0] head, input logic [31:0] seq,
                               input logic marker);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = {seq, head};
        s_tlast  = marker;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        packets_sent++;
    endtask

    // Build a descriptor head with the layer byte placed after the picture id.
    function automatic logic [31:0] pack_descriptor(input logic i_f, input logic p_f,
                                                    input logic l_f, input logic b_f,
                                                    input logic e_f, input logic long_id,
                                                    input logic [2:0] tid, input logic sw,
                                                    input logic [2:0] sid);
        logic [31:0] fill;
        logic [7:0]  b0;
        logic [7:0]  lb;
        fill = $urandom();
        b0   = {i_f, p_f, l_f, fill[4], b_f, e_f, fill[1:0]};
        lb   = {tid, sw, sid, fill[24]};
        if (!i_f) return {b0, lb, fill[15:0]};
        if (!long_id) return {b0, 1'b0, fill[22:16], lb, fill[7:0]};
        return {b0, 1'b1, fill[22:16], fill[15:8], lb};
    endfunction

    // One picture across several spatial layers, with frame starts and ends mostly
    // where they belong and now and then misplaced.
    task automatic send_picture();
        logic              key;
        logic              long_id;
        logic              sw;
        logic [2:0]        tid;
        int unsigned       layers;
        int unsigned       pkts;
        key     = ($urandom_range(0, 3) == 0);
        long_id = 1'($urandom_range(0, 1));
        tid     = ($urandom_range(0, 1) != 0) ? 3'($urandom_range(0, 7)) :
                                                3'($urandom_range(0, 2));
        sw      = ($urandom_range(0, 4) != 0);
        layers  = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(1, 4);
        for (int s = 0; s < layers; s++) begin
            pkts = $urandom_range(1, 3);
            for (int k = 0; k < pkts; k++) begin
                logic b_f;
                logic e_f;
                logic p_f;
                logic l_f;
                b_f = (k == 0);
                e_f = (k == pkts - 1);
                if ($urandom_range(0, 15) == 0) b_f = !b_f;
                if ($urandom_range(0, 15) == 0) e_f = !e_f;
                p_f = !key && (s == 0 || $urandom_range(0, 1) != 0);
                l_f = ($urandom_range(0, 15) != 0);
                send_packet(pack_descriptor(1'($urandom_range(0, 1)), p_f, l_f, b_f, e_f,
                                            long_id, tid, sw, 3'(s)),
                            next_seq,
                            (s == layers - 1 && e_f) || ($urandom_range(0, 31) == 0));
                next_seq = next_seq + (($urandom_range(0, 31) == 0) ? $urandom() : 32'd1);
            end
        end
    endtask

    initial begin
        logic [LayerWidth-1:0] tl;
        logic [LayerWidth-1:0] sl;
        int unsigned           goal;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        next_seq = $urandom();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset values of the targets.
        apb_access(1'b0, AddrTemporal, '0);
        apb_access(1'b0, AddrSpatial, '0);

        // Directed: field extremes, both picture id lengths, missing layer byte,
        // upswitch and downswitch on both layer kinds, sequence wrap below zero.
        send_packet(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_packet({FlagL | FlagB, 8'h12, 16'hA5A5}, 32'h0000_0001, 1'b0);
        send_packet({FlagL | FlagB | FlagE, 8'h02, 16'h0000}, 32'h0000_0000, 1'b0);
        send_packet({FlagI | FlagL | FlagE, 8'h35, 8'h44, 8'h00}, 32'h0000_0005, 1'b0);
        send_packet({FlagE, 24'hFF_FFFF}, 32'h8000_0000, 1'b0);

        set_targets(3'd0, 3'd0);
        send_packet({FlagL | FlagE, 8'h00, 16'h0000}, 32'h0000_0010, 1'b0);
        send_packet({FlagL, 8'h60, 16'h0000}, 32'h0000_0011, 1'b0);
        send_packet({FlagL | FlagB, 8'h32, 16'h0000}, 32'h0000_0012, 1'b1);

        set_targets(3'd3, 3'd7);
        send_packet({FlagL | FlagB, 8'hB0, 16'h0000}, 32'h0000_0020, 1'b0);
        send_packet({FlagL | FlagB, 8'h50, 16'h0000}, 32'h0000_0021, 1'b0);
        send_packet({FlagL, 8'h40, 16'h0000}, 32'h0000_0022, 1'b0);
        send_packet({FlagP | FlagL | FlagB, 8'h02, 16'h0000}, 32'h0000_0023, 1'b0);
        send_packet({FlagL | FlagB, 8'h22, 16'h0000}, 32'h0000_0024, 1'b0);
        send_packet({FlagI | FlagP | FlagL | FlagB, 8'h81, 8'h00, 8'h04}, 32'h0000_0025, 1'b0);
        send_packet({FlagI | FlagL | FlagB | FlagE, 8'h7F, 8'h24, 8'h00}, 32'h0000_0026, 1'b0);
        send_packet({FlagL | FlagE, 8'h04, 16'h0000}, 32'h0000_0027, 1'b0);
        // Climb the spatial layers one by one up to the top layer.
        for (int s = 3; s < 8; s++) begin
            send_packet({FlagL | FlagB, 4'b0000, 3'(s), 1'b0, 16'h0000}, 32'h0000_0030 + s, 1'b0);
        end

        // Random pictures with some noise, one target setting per phase.
        for (int ph = 0; ph < PhaseCount; ph++) begin
            case (ph)
                0, 4: begin tl = 3'd7; sl = 3'd7; end
                1: begin tl = 3'd0; sl = 3'd0; end
                2: begin tl = 3'd7; sl = 3'd0; end
                3: begin tl = 3'd0; sl = 3'd7; end
                default: begin tl = 3'($urandom_range(0, 7)); sl = 3'($urandom_range(0, 7)); end
            endcase
            set_targets(tl, sl);
            if (ph == 0) hold_req = 1'b1;
            if (ph == 5) next_seq = 32'hFFFF_FFF0;
            goal = packets_sent + PhasePackets;
            while (packets_sent < goal) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_packet($urandom(), $urandom(), 1'($urandom_range(0, 1)));
                end else begin
                    send_picture();
                end
            end
        end

        settle();
        repeat (8) @(negedge aclk);
        if (errors == 0) begin
            $display("tb_vp9_svc_layer_selector_unit: clean");
        end else begin
            $display("tb_vp9_svc_layer_selector_unit: errors");
        end
        $finish;
    end

endmodule
